>>> hw/rtl/affine_2d_matrix_engine_defines.svh
// Assertion helpers shared by the checker.
`ifndef AFFINE_2D_MATRIX_ENGINE_DEFINES_SVH
`define AFFINE_2D_MATRIX_ENGINE_DEFINES_SVH

// condition holds in the same cycle
`define AE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define AE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ae_pkg;

    typedef enum logic [1:0] {
        OP_IDENT   = 2'd0,
        OP_COMPOSE = 2'd1,
        OP_INVERT  = 2'd2,
        OP_POINT   = 2'd3
    } ae_op_t;

    localparam int NUM_LANES = 6;
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_ADDR_THRESHOLD = 3'd0;

    typedef logic [NUM_LANES-1:0][31:0] ae_mat_t;

    typedef struct packed {
        logic [1:0]         op;
        logic               prepend;
        logic signed [31:0] b_m00;
        logic signed [31:0] b_m01;
        logic signed [31:0] b_m10;
        logic signed [31:0] b_m11;
        logic signed [31:0] b_m20;
        logic signed [31:0] b_m21;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } ae_in_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] determinant;
        logic               ok;
        logic               is_identity;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } ae_out_t;

    // per-lane command: divide mode, subtract second product, flip quotient sign
    typedef struct packed {
        logic start;
        logic div_mode;
        logic sub;
        logic flip;
    } ae_lane_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ae_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module ae_lane #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ae_pkg::ae_lane_cmd_t cmd,
    input  wire logic signed [31:0]  a0,
    input  wire logic signed [31:0]  b0,
    input  wire logic signed [31:0]  a1,
    input  wire logic signed [31:0]  b1,
    input  wire logic signed [63:0]  addend,
    input  wire logic signed [31:0]  divisor,
    output logic                     busy,
    output logic [31:0]              result
);
    import ae_pkg::*;

    localparam logic [65:0] HALF = 66'd1 << (COEF_FRAC_BITS - 1);

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_SUM  = 6'b000010,
        L_MAG  = 6'b000100,
        L_RND  = 6'b001000,
        L_DIV  = 6'b010000,
        L_FIN  = 6'b100000
    } lane_state_t;

    lane_state_t        state_reg;
    logic               div_reg;
    logic               sub_reg;
    logic               flip_reg;
    logic               dneg_reg;
    logic               neg_reg;
    logic signed [63:0] p0_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] add_reg;
    logic signed [65:0] sum_reg;
    logic [65:0]        mag_reg;
    logic [31:0]        md_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        nb_reg;
    logic [31:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        result_reg;

    logic signed [65:0] e0, e1, ea;
    logic [65:0]        rnd;
    logic               ovf;
    logic [32:0]        trial;
    logic               ge;
    logic [32:0]        q1;

    function automatic logic [31:0] sat32(input logic neg, input logic [65:0] m);
        logic [31:0] r;
        if (neg)
            r = (m >= 66'h8000_0000) ? 32'h8000_0000 : 32'(66'd0 - m);
        else
            r = (m > 66'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        return r;
    endfunction

    always_comb
    begin
        e0    = {{2{p0_reg[63]}}, p0_reg};
        e1    = {{2{p1_reg[63]}}, p1_reg};
        ea    = {{2{add_reg[63]}}, add_reg};
        rnd   = (mag_reg + HALF) >> COEF_FRAC_BITS;
        ovf   = mag_reg >= {2'b00, md_reg, 32'h0};
        trial = {rem_reg, nb_reg[31]};
        ge    = trial >= {1'b0, md_reg};
        q1    = {1'b0, q_reg} + {32'd0, ({rem_reg, 1'b0} >= {1'b0, md_reg})};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE: if (cmd.start) state_reg <= L_SUM;
                L_SUM:  state_reg <= L_MAG;
                L_MAG:  state_reg <= L_RND;
                L_RND:  state_reg <= (div_reg && !ovf) ? L_DIV : L_IDLE;
                L_DIV:  if (cnt_reg == 5'd31) state_reg <= L_FIN;
                L_FIN:  state_reg <= L_IDLE;
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (cmd.start)
                begin
                    p0_reg   <= a0 * b0;
                    p1_reg   <= a1 * b1;
                    add_reg  <= addend;
                    div_reg  <= cmd.div_mode;
                    sub_reg  <= cmd.sub;
                    flip_reg <= cmd.flip;
                    dneg_reg <= divisor[31];
                    md_reg   <= divisor[31] ? 32'd0 - divisor : divisor;
                end
            end
            L_SUM:
            begin
                sum_reg <= sub_reg ? e0 - e1 + ea : e0 + e1 + ea;
            end
            L_MAG:
            begin
                mag_reg <= sum_reg[65] ? 66'd0 - sum_reg : sum_reg;
                neg_reg <= sum_reg[65] ^ (div_reg & (dneg_reg ^ flip_reg));
            end
            L_RND:
            begin
                if (!div_reg)
                    result_reg <= sat32(neg_reg, rnd);
                else if (ovf)
                    result_reg <= sat32(neg_reg, 66'h1_0000_0000);
                else
                begin
                    // quotient fits 32 bits: the high half is already below the divisor
                    rem_reg <= mag_reg[63:32];
                    nb_reg  <= mag_reg[31:0];
                    q_reg   <= 32'd0;
                    cnt_reg <= 5'd0;
                end
            end
            L_DIV:
            begin
                rem_reg <= ge ? 32'(trial - {1'b0, md_reg}) : trial[31:0];
                q_reg   <= {q_reg[30:0], ge};
                nb_reg  <= {nb_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            L_FIN:
            begin
                result_reg <= sat32(neg_reg & (q1 != 33'd0), {33'd0, q1});
            end
            default: ;
        endcase
    end

    assign busy   = state_reg != L_IDLE;
    assign result = result_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ae_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module ae_merge #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire ae_pkg::ae_mat_t     mat,
    input  wire logic signed [31:0]  det,
    input  wire logic                ok,
    input  wire logic signed [31:0]  ox,
    input  wire logic signed [31:0]  oy,
    input  wire logic [15:0]         thr,
    output ae_pkg::ae_out_t          res
);
    import ae_pkg::*;

    localparam logic [32:0] ONE_FX = 33'd1 << COEF_FRAC_BITS;

    logic [NUM_LANES-1:0] near;
    logic [32:0]          diff;
    logic [32:0]          dmag;

    always_comb
    begin
        diff = 33'd0;
        dmag = 33'd0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            diff = {mat[i][31], mat[i]} - ((i == 0 || i == 3) ? ONE_FX : 33'd0);
            dmag = diff[32] ? 33'd0 - diff : diff;
            near[i] = dmag <= {17'd0, thr};
        end
        res.m00         = mat[0];
        res.m01         = mat[1];
        res.m10         = mat[2];
        res.m11         = mat[3];
        res.m20         = mat[4];
        res.m21         = mat[5];
        res.determinant = det;
        res.ok          = ok;
        res.is_identity = &near;
        res.out_x       = ox;
        res.out_y       = oy;
    end

endmodule
`default_nettype wire

>>> hw/rtl/affine_2d_matrix_engine.sv
// Identity and a refused inversion go T_DET, T_DWAIT, T_OUT; compose and point first run
// T_RUN and T_WAIT; a completed inversion adds T_RUN and T_WAIT with a restoring divide per
// lane, then T_DET again. One transaction in flight; in_ready returns once the result is
// registered; a result waiting on out_ready stalls only the next result. Reset:
// asynchronous active-low; matrix to identity, threshold to 0.
`timescale 1ns / 1ps
`default_nettype none
module affine_2d_matrix_engine #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire ae_pkg::ae_in_t            in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output ae_pkg::ae_out_t                out_data,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ae_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ae_pkg::*;

    localparam logic [31:0] ONE_FX = 32'd1 << COEF_FRAC_BITS;
    localparam ae_mat_t IDENT_MAT = {32'd0, 32'd0, ONE_FX, 32'd0, 32'd0, ONE_FX};

    typedef enum logic [6:0] {
        T_IDLE  = 7'b0000001,
        T_RUN   = 7'b0000010,
        T_WAIT  = 7'b0000100,
        T_DET   = 7'b0001000,
        T_DWAIT = 7'b0010000,
        T_OUT   = 7'b0100000,
        T_SPARE = 7'b1000000
    } top_state_t;

    top_state_t         state_reg, state_next;
    ae_in_t             item_reg;
    ae_mat_t            mat_reg;
    logic [15:0]        thr_reg;
    logic signed [31:0] det_reg;
    logic               ok_reg;
    logic               inv_pend_reg;
    logic signed [31:0] ox_reg, oy_reg;
    ae_out_t            out_reg;
    logic               out_valid_reg;

    ae_lane_cmd_t       lcmd [NUM_LANES];
    logic signed [31:0] la0 [NUM_LANES];
    logic signed [31:0] lb0 [NUM_LANES];
    logic signed [31:0] la1 [NUM_LANES];
    logic signed [31:0] lb1 [NUM_LANES];
    logic signed [63:0] ladd [NUM_LANES];
    logic [31:0]        lres [NUM_LANES];
    logic [NUM_LANES-1:0] lbusy;

    logic signed [31:0] bm [NUM_LANES];
    logic signed [31:0] xm [NUM_LANES];
    logic signed [31:0] ym [NUM_LANES];
    logic [31:0]        dmag;
    logic               singular;
    logic               cfg_wr;
    ae_out_t            merged;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_ADDR_THRESHOLD) ? {16'd0, thr_reg} : 32'd0;
    assign dmag     = lres[0][31] ? 32'd0 - lres[0] : lres[0];
    assign singular = dmag <= {16'd0, thr_reg};

    // operand setup for the lanes
    always_comb
    begin
        bm[0] = item_reg.b_m00;
        bm[1] = item_reg.b_m01;
        bm[2] = item_reg.b_m10;
        bm[3] = item_reg.b_m11;
        bm[4] = item_reg.b_m20;
        bm[5] = item_reg.b_m21;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            xm[i] = item_reg.prepend ? bm[i] : $signed(mat_reg[i]);
            ym[i] = item_reg.prepend ? $signed(mat_reg[i]) : bm[i];
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lcmd[i] = '0;
            la0[i]  = '0;
            lb0[i]  = '0;
            la1[i]  = '0;
            lb1[i]  = '0;
            ladd[i] = '0;
        end
        if (state_reg == T_DET)
        begin
            lcmd[0].start = 1'b1;
            lcmd[0].sub   = 1'b1;
            la0[0] = mat_reg[0];
            lb0[0] = mat_reg[3];
            la1[0] = mat_reg[1];
            lb1[0] = mat_reg[2];
        end
        else if (state_reg == T_RUN)
        begin
            unique case (item_reg.op)
                OP_COMPOSE:
                begin
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        lcmd[i].start = 1'b1;
                        la0[i] = xm[2 * (i / 2)];
                        la1[i] = xm[2 * (i / 2) + 1];
                        lb0[i] = ym[i % 2];
                        lb1[i] = ym[2 + i % 2];
                        ladd[i] = (i >= 4) ? ({{32{ym[i][31]}}, ym[i]} << COEF_FRAC_BITS)
                                           : 64'sd0;
                    end
                end
                OP_POINT:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        lcmd[i].start = 1'b1;
                        la0[i]  = item_reg.point_x;
                        lb0[i]  = mat_reg[i];
                        la1[i]  = item_reg.point_y;
                        lb1[i]  = mat_reg[2 + i];
                        ladd[i] = {{32{mat_reg[4 + i][31]}}, mat_reg[4 + i]};
                    end
                end
                OP_INVERT:
                begin
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        lcmd[i].start    = 1'b1;
                        lcmd[i].div_mode = 1'b1;
                    end
                    lcmd[1].flip = 1'b1;
                    lcmd[2].flip = 1'b1;
                    lcmd[5].flip = 1'b1;
                    lcmd[4].sub  = 1'b1;
                    lcmd[5].sub  = 1'b1;
                    la0[0] = mat_reg[3]; lb0[0] = ONE_FX;
                    la0[1] = mat_reg[1]; lb0[1] = ONE_FX;
                    la0[2] = mat_reg[2]; lb0[2] = ONE_FX;
                    la0[3] = mat_reg[0]; lb0[3] = ONE_FX;
                    la0[4] = mat_reg[2]; lb0[4] = mat_reg[5];
                    la1[4] = mat_reg[4]; lb1[4] = mat_reg[3];
                    la0[5] = mat_reg[0]; lb0[5] = mat_reg[5];
                    la1[5] = mat_reg[4]; lb1[5] = mat_reg[1];
                end
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            ae_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (lcmd[g]),
                .a0      (la0[g]),
                .b0      (lb0[g]),
                .a1      (la1[g]),
                .b1      (lb1[g]),
                .addend  (ladd[g]),
                .divisor (det_reg),
                .busy    (lbusy[g]),
                .result  (lres[g])
            );
        end
    endgenerate

    ae_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
        .mat (mat_reg),
        .det (det_reg),
        .ok  (ok_reg),
        .ox  (ox_reg),
        .oy  (oy_reg),
        .thr (thr_reg),
        .res (merged)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.op)
                        OP_COMPOSE, OP_POINT: state_next = T_RUN;
                        OP_IDENT, OP_INVERT:  state_next = T_DET;
                        default:              state_next = T_DET;
                    endcase
                end
            end
            T_RUN:   state_next = T_WAIT;
            T_WAIT:  if (lbusy == '0) state_next = T_DET;
            T_DET:   state_next = T_DWAIT;
            T_DWAIT:
            begin
                if (!lbusy[0])
                    state_next = (inv_pend_reg && !singular) ? T_RUN : T_OUT;
            end
            T_OUT:   if (!out_valid_reg || out_ready) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= 16'd0;
            inv_pend_reg  <= 1'b0;
            mat_reg       <= IDENT_MAT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr == REG_ADDR_THRESHOLD)
                thr_reg <= pwdata[15:0];
            if (state_reg == T_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.op == OP_IDENT)
                            mat_reg <= IDENT_MAT;
                        inv_pend_reg <= in_data.op == OP_INVERT;
                    end
                end
                T_WAIT:
                begin
                    if (lbusy == '0 && item_reg.op != OP_POINT)
                    begin
                        for (int i = 0; i < NUM_LANES; i++)
                            mat_reg[i] <= lres[i];
                    end
                end
                T_DWAIT:
                begin
                    if (!lbusy[0])
                        inv_pend_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    item_reg <= in_data;
                    ok_reg   <= 1'b1;
                    ox_reg   <= 32'sd0;
                    oy_reg   <= 32'sd0;
                end
            end
            T_WAIT:
            begin
                if (lbusy == '0 && item_reg.op == OP_POINT)
                begin
                    ox_reg <= lres[0];
                    oy_reg <= lres[1];
                end
            end
            T_DWAIT:
            begin
                if (!lbusy[0])
                begin
                    det_reg <= lres[0];
                    if (inv_pend_reg && singular)
                        ok_reg <= 1'b0;
                end
            end
            T_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    out_reg <= merged;
            end
            default: ;
        endcase
    end

    assign in_ready  = state_reg == T_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ae_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "affine_2d_matrix_engine_defines.svh"
module ae_checker (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire ae_pkg::ae_out_t out_data
);
    `AE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `AE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")
    `AE_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken while busy")
    `AE_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready), "result without transaction")
endmodule

bind affine_2d_matrix_engine ae_checker u_ae_checker (.*);
`default_nettype wire
